// ===== src/gtoe_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Geodetic to ECEF package
// Shared constants, register indexes and arithmetic helpers for the
// geodetic to earth-centred earth-fixed converter.
// ----------------------------------------------------------------------------
package gtoe_pkg;

  localparam int CORDIC_STAGES_DEF = 32;
  localparam int FRAC_BITS_DEF     = 30;

  // Configuration register indexes.
  localparam logic REG_SEMI_MAJOR = 1'b0;
  localparam logic REG_ECC        = 1'b1;

  localparam logic [32:0] SEMI_MAJOR_RST = 33'd6378137000;
  localparam logic [31:0] ECC_RST        = 32'd28752143;

  localparam logic [63:0]        GAIN_Q40       = 64'd667681663043;
  localparam logic signed [32:0] PI_Q30         = 33'sd3373259426;
  localparam logic signed [63:0] QUARTER_PI_Q61 = 64'sh1921FB54442D1847;
  localparam logic signed [63:0] OUT_LIMIT      = 64'sd8000000000;
  localparam logic [63:0]        MAG_CAP        = 64'd1 << 62;

  // Stage offsets after the CORDIC outputs are registered.
  localparam int J_S2   = 1;
  localparam int J_E2   = 3;
  localparam int J_T    = 5;
  localparam int J_SQ   = 6;
  localparam int SQ_N   = 32;
  localparam int J_DIV  = J_SQ + SQ_N;
  localparam int DIV_N  = 64;
  localparam int J_NH   = J_DIV + DIV_N;
  localparam int J_P    = J_NH + 1;
  localparam int J_M    = J_P + 2;
  localparam int J_XYZ  = J_M + 1;
  localparam int J_OUT  = J_XYZ + 2;
  localparam int PRE_LAT = 2;

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_t;

  typedef struct packed {
    logic [63:0] p00;
    logic [63:0] p01;
    logic [63:0] p10;
    logic [63:0] p11;
  } pp_t;

  function automatic int pipe_latency(input int Cs);
    return Cs + PRE_LAT + J_OUT;
  endfunction

  // Floor of 2^Shift over Den, by restoring long division (Shift <= 61).
  function automatic longint pow2_over(input int Shift, input int Den);
    longint quo;
    longint rem;
    quo = 0;
    rem = 0;
    for (int b = 61; b >= 0; b--) begin
      rem = (rem << 1) | ((b == Shift) ? 64'sd1 : 64'sd0);
      if (rem >= longint'(Den)) begin
        rem = rem - longint'(Den);
        quo = quo | (longint'(1) << b);
      end
    end
    return quo;
  endfunction

  // Arctangent of 2^-Idx in Q61 from the truncated alternating series.
  function automatic logic signed [63:0] atan_q61(input int Idx);
    logic signed [63:0] sum;
    longint term;
    int k;
    sum = '0;
    if (Idx == 0) begin
      sum = QUARTER_PI_Q61;
    end else begin
      for (k = 0; (2 * k + 1) * Idx <= 61; k++) begin
        term = pow2_over(61 - (2 * k + 1) * Idx, 2 * k + 1);
        sum  = k[0] ? sum - term : sum + term;
      end
    end
    return sum;
  endfunction

  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  // Four 32 by 32 partial products of two 64-bit magnitudes.
  function automatic pp_t pp4(input logic [63:0] a, input logic [63:0] b);
    pp_t p;
    p.p00 = 64'(a[31:0])  * 64'(b[31:0]);
    p.p01 = 64'(a[31:0])  * 64'(b[63:32]);
    p.p10 = 64'(a[63:32]) * 64'(b[31:0]);
    p.p11 = 64'(a[63:32]) * 64'(b[63:32]);
    return p;
  endfunction

  // Rounds half up, shifts right by S and caps the magnitude at 2^62.
  function automatic logic [63:0] sum_round(input pp_t p, input int S);
    logic [127:0] full;
    logic [127:0] q;
    full = {64'd0, p.p00} + {32'd0, p.p01, 32'd0} + {32'd0, p.p10, 32'd0}
         + {p.p11, 64'd0} + (128'd1 << (S - 1));
    q = full >> S;
    return (q > {64'd0, MAG_CAP}) ? MAG_CAP : q[63:0];
  endfunction

  function automatic logic signed [63:0] sgn_apply(input logic neg, input logic [63:0] m);
    return neg ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [33:0] sat34(input logic signed [63:0] v);
    logic signed [63:0] c;
    if (v > OUT_LIMIT) c = OUT_LIMIT;
    else if (v < -OUT_LIMIT) c = -OUT_LIMIT;
    else c = v;
    return c[33:0];
  endfunction

endpackage
`default_nettype wire

// ===== src/geodetic_to_ecef.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Geodetic to ECEF converter
// Each input transfer carries latitude, longitude (binary angles, 2^31 = pi)
// and height in mm; each output transfer carries saturated X, Y, Z in mm.
// A transfer happens on a rising edge with valid high and stall low.
// The ellipsoid axis and eccentricity squared are to be written on the cfg
// port (index 0 and 1) only while no transfer is in flight; the block itself
// does not enforce this. The pipeline depth is set by the CORDIC stages, the
// 32-stage square root and the 64-stage divider. A new item is taken every
// cycle unless the receiver stalls a waiting result: then the whole pipeline
// holds and in_stall rises until the result is taken; nothing is lost.
// Reset empties the pipeline and restores the default ellipsoid.
// ----------------------------------------------------------------------------
module geodetic_to_ecef import gtoe_pkg::*; #(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF,
  parameter int FRAC_BITS     = FRAC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [31:0] lat_angle,
  input  wire logic signed [31:0] lon_angle,
  input  wire logic signed [27:0] height_mm,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed      [33:0] ecef_x,
  output logic signed      [33:0] ecef_y,
  output logic signed      [33:0] ecef_z,
  input  wire logic               cfg_we,
  input  wire logic               cfg_index,
  input  wire logic        [32:0] cfg_data
);

  localparam int LAT = pipe_latency(CORDIC_STAGES);

  logic [32:0] semi_major_axis;
  logic [31:0] ecc_squared;
  logic        vld [0:LAT-1];
  logic        ce;

  assign ce        = !vld[LAT-1] || !out_stall;
  assign in_stall  = !ce;
  assign out_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      semi_major_axis <= SEMI_MAJOR_RST;
      ecc_squared     <= ECC_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SEMI_MAJOR: semi_major_axis <= cfg_data;
        REG_ECC:        ecc_squared     <= cfg_data[31:0];
        default:        ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < LAT; k++) vld[k] <= 1'b0;
    end else if (ce) begin
      vld[0] <= in_valid;
      for (int k = 1; k < LAT; k++) vld[k] <= vld[k-1];
    end
  end

  gtoe_datapath #(
    .CORDIC_STAGES(CORDIC_STAGES),
    .FRAC_BITS    (FRAC_BITS)
  ) u_datapath (
    .clk            (clk),
    .ce             (ce),
    .lat_angle      (lat_angle),
    .lon_angle      (lon_angle),
    .height_mm      (height_mm),
    .semi_major_axis(semi_major_axis),
    .ecc_squared    (ecc_squared),
    .ecef_x         (ecef_x),
    .ecef_y         (ecef_y),
    .ecef_z         (ecef_z)
  );

  // The input side only waits while a finished result is held back.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a held result");

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (ecef_x <= 34'sd8000000000 && ecef_x >= -34'sd8000000000 &&
                   ecef_y <= 34'sd8000000000 && ecef_y >= -34'sd8000000000 &&
                   ecef_z <= 34'sd8000000000 && ecef_z >= -34'sd8000000000))
    else $error("result outside saturation range");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result presented right after reset");

endmodule
`default_nettype wire

// ===== src/gtoe_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Geodetic to ECEF datapath
// Two rotation CORDICs, prime-vertical radius by pipelined square root and
// restoring division, and the final scaling products. Advances on ce.
// ----------------------------------------------------------------------------
module gtoe_datapath import gtoe_pkg::*; #(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF,
  parameter int FRAC_BITS     = FRAC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               ce,
  input  wire logic signed [31:0] lat_angle,
  input  wire logic signed [31:0] lon_angle,
  input  wire logic signed [27:0] height_mm,
  input  wire logic        [32:0] semi_major_axis,
  input  wire logic        [31:0] ecc_squared,
  output logic signed      [33:0] ecef_x,
  output logic signed      [33:0] ecef_y,
  output logic signed      [33:0] ecef_z
);

  localparam int CS = CORDIC_STAGES;
  localparam int F  = FRAC_BITS;
  localparam int XW = F + 3;
  localparam int TW = F + 2;
  localparam int SH = 40 - F;
  localparam logic [63:0] X0_FULL =
    (GAIN_Q40 + ((SH == 0) ? 64'd0 : (64'd1 << (SH - 1)))) >> SH;
  localparam logic signed [XW-1:0] X0    = XW'(X0_FULL);
  localparam logic signed [XW-1:0] UNITX = XW'(64'd1 << F);
  localparam logic [63:0] ONE64 = 64'd1 << F;

  typedef struct packed {
    logic signed [TW-1:0] cl;
    logic signed [TW-1:0] sl;
    logic signed [TW-1:0] co;
    logic signed [TW-1:0] so;
    logic signed [27:0]   h;
  } trg_t;

  // ---------------- CORDIC, latitude in lane 0 and longitude in lane 1
  logic signed [31:0]   ang [0:1];
  logic signed [XW-1:0] cx  [0:1][0:CS];
  logic signed [XW-1:0] cy  [0:1][0:CS];
  logic signed [63:0]   cz  [0:1][0:CS];
  quad_t                cq  [0:1][0:CS];
  logic signed [TW-1:0] c_o [0:1];
  logic signed [TW-1:0] s_o [0:1];
  logic signed [27:0]   h_d [0:CS+1];

  assign ang[0] = lat_angle;
  assign ang[1] = lon_angle;

  for (genvar a = 0; a < 2; a++) begin : g_lane
    logic [31:0]        us;
    quad_t              q;
    logic [31:0]        d;
    logic signed [29:0] r;
    logic signed [62:0] zp;
    logic signed [XW-1:0] xc, yc;

    always_comb begin
      us = ang[a] + 32'h2000_0000;
      q  = quad_t'(us[31:30]);
      d  = ang[a] - {us[31:30], 30'd0};
      r  = $signed(d[29:0]);
      zp = r * PI_Q30;
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        cx[a][0] <= X0;
        cy[a][0] <= '0;
        cz[a][0] <= 64'(zp);
        cq[a][0] <= q;
      end
    end

    for (genvar i = 0; i < CS; i++) begin : g_stage
      localparam logic signed [63:0] ATAN = atan_q61(i);
      logic signed [XW-1:0] dx, dy;
      assign dx = cy[a][i] >>> i;
      assign dy = cx[a][i] >>> i;
      always_ff @(posedge clk) begin
        if (ce) begin
          if (!cz[a][i][63]) begin
            cx[a][i+1] <= cx[a][i] - dx;
            cy[a][i+1] <= cy[a][i] + dy;
            cz[a][i+1] <= cz[a][i] - ATAN;
          end else begin
            cx[a][i+1] <= cx[a][i] + dx;
            cy[a][i+1] <= cy[a][i] - dy;
            cz[a][i+1] <= cz[a][i] + ATAN;
          end
          cq[a][i+1] <= cq[a][i];
        end
      end
    end

    always_comb begin
      xc = cx[a][CS];
      yc = cy[a][CS];
      if (xc > UNITX) xc = UNITX;
      else if (xc < -UNITX) xc = -UNITX;
      if (yc > UNITX) yc = UNITX;
      else if (yc < -UNITX) yc = -UNITX;
    end

    // Quarter-turn rotation back to the full circle.
    always_ff @(posedge clk) begin
      if (ce) begin
        case (cq[a][CS])
          QUAD_0: begin c_o[a] <= TW'(xc);  s_o[a] <= TW'(yc);  end
          QUAD_1: begin c_o[a] <= TW'(-yc); s_o[a] <= TW'(xc);  end
          QUAD_2: begin c_o[a] <= TW'(-xc); s_o[a] <= TW'(-yc); end
          QUAD_3: begin c_o[a] <= TW'(yc);  s_o[a] <= TW'(-xc); end
          default: begin c_o[a] <= TW'(xc); s_o[a] <= TW'(yc); end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      h_d[0] <= height_mm;
      for (int k = 1; k <= CS + 1; k++) h_d[k] <= h_d[k-1];
    end
  end

  // ---------------- Side data delay line
  trg_t trg0;
  trg_t trg [1:J_XYZ-1];

  always_comb begin
    trg0.cl = c_o[0];
    trg0.sl = s_o[0];
    trg0.co = c_o[1];
    trg0.so = s_o[1];
    trg0.h  = h_d[CS+1];
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      trg[1] <= trg0;
      for (int k = 2; k < J_XYZ; k++) trg[k] <= trg[k-1];
    end
  end

  // ---------------- sin^2 lat, e2 sin^2 lat and the root argument
  pp_t         pp_s2, pp_e2;
  logic [63:0] s2, e2s2, t;
  logic [63:0] sl_mag;

  assign sl_mag = mag64(64'(trg0.sl));

  always_ff @(posedge clk) begin
    if (ce) begin
      pp_s2 <= pp4(sl_mag, sl_mag);
      s2    <= sum_round(pp_s2, F);
      pp_e2 <= pp4({32'd0, ecc_squared}, s2);
      e2s2  <= sum_round(pp_e2, 32);
      // An eccentricity at or above one would leave nothing under the root.
      t     <= ((e2s2 >= ONE64) ? 64'd1 : (ONE64 - e2s2)) << (62 - F);
    end
  end

  // ---------------- Square root, one result bit per stage
  logic [63:0] sq_rem [0:SQ_N-1];
  logic [63:0] sq_res [0:SQ_N-1];

  for (genvar i = 0; i < SQ_N; i++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * i);
    logic [63:0] rem_in, res_in, trial;
    if (i == 0) begin : g_first
      assign rem_in = t;
      assign res_in = '0;
    end else begin : g_next
      assign rem_in = sq_rem[i-1];
      assign res_in = sq_res[i-1];
    end
    assign trial = res_in + BIT;
    always_ff @(posedge clk) begin
      if (ce) begin
        if (rem_in >= trial) begin
          sq_rem[i] <= rem_in - trial;
          sq_res[i] <= (res_in >> 1) + BIT;
        end else begin
          sq_rem[i] <= rem_in;
          sq_res[i] <= res_in >> 1;
        end
      end
    end
  end

  // ---------------- N = a * 2^31 / root, one quotient bit per stage
  logic [63:0] dividend;
  logic [31:0] dv_rem [0:DIV_N-1];
  logic [63:0] dv_quo [0:DIV_N-1];
  logic [31:0] dv_den [0:DIV_N-1];

  assign dividend = {semi_major_axis, 31'd0};

  for (genvar i = 0; i < DIV_N; i++) begin : g_div
    logic [31:0] rem_in, den_in;
    logic [63:0] quo_in;
    logic [32:0] tmp;
    logic        ge;
    if (i == 0) begin : g_first
      assign rem_in = '0;
      assign quo_in = '0;
      assign den_in = (sq_res[SQ_N-1] == 64'd0) ? 32'd1 : sq_res[SQ_N-1][31:0];
    end else begin : g_next
      assign rem_in = dv_rem[i-1];
      assign quo_in = dv_quo[i-1];
      assign den_in = dv_den[i-1];
    end
    assign tmp = {rem_in, dividend[63-i]};
    assign ge  = tmp >= {1'b0, den_in};
    always_ff @(posedge clk) begin
      if (ce) begin
        dv_rem[i] <= ge ? 32'(tmp - {1'b0, den_in}) : tmp[31:0];
        dv_quo[i] <= {quo_in[62:0], ge};
        dv_den[i] <= den_in;
      end
    end
  end

  // ---------------- (N+h) cos lat and N(1-e2)+h
  logic [63:0]        n_r, mn;
  logic signed [63:0] nh, p, p_d, m;
  pp_t                pp_p, pp_mn;
  logic               neg_p;

  always_ff @(posedge clk) begin
    if (ce) begin
      n_r   <= dv_quo[DIV_N-1];
      nh    <= $signed(dv_quo[DIV_N-1]) + 64'(trg[J_NH-1].h);
      pp_p  <= pp4(mag64(nh), mag64(64'(trg[J_P-1].cl)));
      neg_p <= nh[63] ^ trg[J_P-1].cl[TW-1];
      pp_mn <= pp4(n_r, 64'(33'h1_0000_0000 - {1'b0, ecc_squared}));
      p     <= sgn_apply(neg_p, sum_round(pp_p, F));
      mn    <= sum_round(pp_mn, 32);
      p_d   <= p;
      m     <= $signed(mn) + 64'(trg[J_M-1].h);
    end
  end

  // ---------------- Final products and saturation
  pp_t                pp_x, pp_y, pp_z;
  logic               neg_x, neg_y, neg_z;
  logic signed [63:0] vx, vy, vz;

  always_ff @(posedge clk) begin
    if (ce) begin
      pp_x   <= pp4(mag64(p_d), mag64(64'(trg[J_XYZ-1].co)));
      pp_y   <= pp4(mag64(p_d), mag64(64'(trg[J_XYZ-1].so)));
      pp_z   <= pp4(mag64(m), mag64(64'(trg[J_XYZ-1].sl)));
      neg_x  <= p_d[63] ^ trg[J_XYZ-1].co[TW-1];
      neg_y  <= p_d[63] ^ trg[J_XYZ-1].so[TW-1];
      neg_z  <= m[63] ^ trg[J_XYZ-1].sl[TW-1];
      vx     <= sgn_apply(neg_x, sum_round(pp_x, F));
      vy     <= sgn_apply(neg_y, sum_round(pp_y, F));
      vz     <= sgn_apply(neg_z, sum_round(pp_z, F));
      ecef_x <= sat34(vx);
      ecef_y <= sat34(vy);
      ecef_z <= sat34(vz);
    end
  end

endmodule
`default_nettype wire
